@@ rtl/core/shw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package shw_pkg;

  // Width of the millisecond time base
  localparam int TIME_BITS = 48;
  // Configuration register width
  localparam int CFG_BITS = 32;
  // Compare width wide enough for both a time difference and a threshold
  localparam int CMP_BITS = TIME_BITS + CFG_BITS;

  // Configuration register indexes
  localparam logic CFG_STALE_THRESHOLD  = 1'b0;
  localparam logic CFG_RECOVERY_TIMEOUT = 1'b1;

  localparam logic [CFG_BITS-1:0] STALE_THRESHOLD_RST  = CFG_BITS'(2000);
  localparam logic [CFG_BITS-1:0] RECOVERY_TIMEOUT_RST = CFG_BITS'(5000);

  typedef enum logic [2:0] {
    OP_SET_MIRRORING  = 3'd0,
    OP_FRAME          = 3'd1,
    OP_LOCKED         = 3'd2,
    OP_RESUMED        = 3'd3,
    OP_DEVICE_PAUSED  = 3'd4,
    OP_DEVICE_RESUMED = 3'd5,
    OP_TICK           = 3'd6,
    OP_REFRESH_FAILED = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE             = 2'd0,
    ACT_REFRESH_RENDERER = 2'd1,
    ACT_RESTART_RECEIVER = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    HLTH_IDLE         = 4'd0,
    HLTH_LOCKED       = 4'd1,
    HLTH_PAUSED       = 4'd2,
    HLTH_RECONNECTING = 4'd3,
    HLTH_RESTORING    = 4'd4,
    HLTH_RESUMING     = 4'd5,
    HLTH_WAITING      = 4'd6,
    HLTH_STALLED      = 4'd7,
    HLTH_LIVE         = 4'd8
  } health_t;

endpackage

`default_nettype wire

@@ rtl/core/stream_health_watchdog.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An input transfer passes through the input register and then the result register.
// Throughput: one event per cycle unless out_stall holds a valid result; the flag update
// and subtract-compares sit between the registers, and state is written on the same edge.
// Reset (rst_n low, synchronous): all flags and valid bits clear, stale threshold
// returns to 2000 ms and recovery timeout to 5000 ms; stored timestamps are not cleared.
module stream_health_watchdog (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration writes
  input  wire                                 cfg_we,
  input  wire                                 cfg_index,
  input  wire [shw_pkg::CFG_BITS-1:0]         cfg_wdata,
  // event input
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [2:0]                           in_opcode,
  input  wire                                 in_mirroring_on,
  input  wire [shw_pkg::TIME_BITS-1:0]        in_now_ms,
  // result output
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_action,
  output logic [3:0]                          out_health,
  output logic signed [shw_pkg::TIME_BITS:0]  out_ms_since_frame
);
  import shw_pkg::*;

  // configuration registers
  logic [CFG_BITS-1:0]  stale_thr_r;
  logic [CFG_BITS-1:0]  recov_tmo_r;

  // input register
  logic                 s1_valid_r;
  opcode_t              s1_op_r;
  logic                 s1_mir_r;
  logic [TIME_BITS-1:0] s1_now_r;

  // watchdog state
  logic                 mirroring_r, mirroring_nxt;
  logic                 locked_r, locked_nxt;
  logic                 paused_r, paused_nxt;
  logic                 restoring_r, restoring_nxt;
  logic                 resuming_r, resuming_nxt;
  logic                 restart_r, restart_nxt;
  logic                 frame_seen_r, frame_seen_nxt;
  logic [TIME_BITS-1:0] last_frame_r, last_frame_nxt;
  logic                 resume_pend_r, resume_pend_nxt;
  logic [TIME_BITS-1:0] resume_start_r, resume_start_nxt;

  // result register
  logic                 out_valid_r;
  action_t              action_r, action_nxt;
  health_t              health_r, health_nxt;
  logic [TIME_BITS:0]   since_r, since_nxt;

  logic                 advance;
  logic [TIME_BITS-1:0] frame_diff;
  logic [TIME_BITS-1:0] resume_diff;
  logic                 frame_gt;
  logic                 tmo_hit;

  // move the input register into the result register when the result slot frees up
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_thr_r <= STALE_THRESHOLD_RST;
      recov_tmo_r <= RECOVERY_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STALE_THRESHOLD:  stale_thr_r <= cfg_wdata;
        CFG_RECOVERY_TIMEOUT: recov_tmo_r <= cfg_wdata;
        default:              stale_thr_r <= stale_thr_r;
      endcase
    end
  end

  // capture input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r  <= opcode_t'(in_opcode);
      s1_mir_r <= in_mirroring_on;
      s1_now_r <= in_now_ms;
    end
  end

  // resume timeout check against the stored start time
  assign resume_diff = s1_now_r - resume_start_r;
  assign tmo_hit     = (s1_now_r >= resume_start_r) &&
                       (CMP_BITS'(resume_diff) >= CMP_BITS'(recov_tmo_r));

  // apply the event to the flags
  always_comb begin
    mirroring_nxt    = mirroring_r;
    locked_nxt       = locked_r;
    paused_nxt       = paused_r;
    restoring_nxt    = restoring_r;
    resuming_nxt     = resuming_r;
    restart_nxt      = restart_r;
    frame_seen_nxt   = frame_seen_r;
    last_frame_nxt   = last_frame_r;
    resume_pend_nxt  = resume_pend_r;
    resume_start_nxt = resume_start_r;
    action_nxt       = ACT_NONE;
    case (s1_op_r)
      OP_SET_MIRRORING: begin
        if (s1_mir_r != mirroring_r) begin
          mirroring_nxt   = s1_mir_r;
          locked_nxt      = 1'b0;
          paused_nxt      = 1'b0;
          restoring_nxt   = 1'b0;
          resuming_nxt    = 1'b0;
          restart_nxt     = 1'b0;
          frame_seen_nxt  = 1'b0;
          resume_pend_nxt = 1'b0;
        end
      end
      OP_FRAME: begin
        if (mirroring_r) begin
          last_frame_nxt = s1_now_r;
          frame_seen_nxt = 1'b1;
          // a frame ends a recovery that is not blocked
          if (!locked_r && !paused_r && (restoring_r || resuming_r) && !restart_r) begin
            restoring_nxt   = 1'b0;
            resuming_nxt    = 1'b0;
            resume_pend_nxt = 1'b0;
          end
        end
      end
      OP_LOCKED: begin
        if (mirroring_r) begin
          locked_nxt      = 1'b1;
          restoring_nxt   = 1'b0;
          restart_nxt     = 1'b0;
          resume_pend_nxt = 1'b0;
        end
      end
      OP_RESUMED: begin
        locked_nxt = 1'b0;
        if (mirroring_r && !restoring_r && !restart_r) begin
          restoring_nxt    = 1'b1;
          resume_start_nxt = s1_now_r;
          resume_pend_nxt  = 1'b1;
          action_nxt       = ACT_REFRESH_RENDERER;
        end
      end
      OP_DEVICE_PAUSED: begin
        if (mirroring_r) begin
          paused_nxt      = 1'b1;
          resuming_nxt    = 1'b0;
          restart_nxt     = 1'b0;
          resume_pend_nxt = 1'b0;
        end
      end
      OP_DEVICE_RESUMED: begin
        if (mirroring_r) begin
          paused_nxt       = 1'b0;
          resuming_nxt     = 1'b1;
          restart_nxt      = 1'b0;
          resume_start_nxt = s1_now_r;
          resume_pend_nxt  = 1'b1;
        end
      end
      OP_TICK: begin
        if (mirroring_r && !paused_r && (restoring_r || resuming_r) && !restart_r &&
            resume_pend_r && tmo_hit) begin
          restoring_nxt = 1'b0;
          resuming_nxt  = 1'b0;
          restart_nxt   = 1'b1;
          action_nxt    = ACT_RESTART_RECEIVER;
        end
      end
      OP_REFRESH_FAILED: begin
        if (mirroring_r) begin
          restoring_nxt = 1'b0;
          restart_nxt   = 1'b1;
        end
      end
      default: begin
        action_nxt = ACT_NONE;
      end
    endcase
  end

  // time since the last frame, after the update
  assign frame_diff = s1_now_r - last_frame_nxt;
  assign frame_gt   = s1_now_r > last_frame_nxt;

  always_comb begin
    if (!frame_seen_nxt) begin
      since_nxt = '1;
    end else if (frame_gt) begin
      since_nxt = {1'b0, frame_diff};
    end else begin
      since_nxt = '0;
    end
  end

  // classify health from the updated flags
  always_comb begin
    if (!mirroring_nxt) begin
      health_nxt = HLTH_IDLE;
    end else if (locked_nxt) begin
      health_nxt = HLTH_LOCKED;
    end else if (paused_nxt) begin
      health_nxt = HLTH_PAUSED;
    end else if (restart_nxt) begin
      health_nxt = HLTH_RECONNECTING;
    end else if (restoring_nxt) begin
      health_nxt = HLTH_RESTORING;
    end else if (resuming_nxt) begin
      health_nxt = HLTH_RESUMING;
    end else if (!frame_seen_nxt) begin
      health_nxt = HLTH_WAITING;
    end else if (frame_gt && (CMP_BITS'(frame_diff) > CMP_BITS'(stale_thr_r))) begin
      health_nxt = HLTH_STALLED;
    end else begin
      health_nxt = HLTH_LIVE;
    end
  end

  // commit state on each processed event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirroring_r   <= 1'b0;
      locked_r      <= 1'b0;
      paused_r      <= 1'b0;
      restoring_r   <= 1'b0;
      resuming_r    <= 1'b0;
      restart_r     <= 1'b0;
      frame_seen_r  <= 1'b0;
      resume_pend_r <= 1'b0;
    end else if (s1_valid_r && advance) begin
      mirroring_r   <= mirroring_nxt;
      locked_r      <= locked_nxt;
      paused_r      <= paused_nxt;
      restoring_r   <= restoring_nxt;
      resuming_r    <= resuming_nxt;
      restart_r     <= restart_nxt;
      frame_seen_r  <= frame_seen_nxt;
      resume_pend_r <= resume_pend_nxt;
    end
  end

  // hold timestamps and result payload
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      last_frame_r   <= last_frame_nxt;
      resume_start_r <= resume_start_nxt;
      action_r       <= action_nxt;
      health_r       <= health_nxt;
      since_r        <= since_nxt;
    end
  end

  // result valid: load on advance, drop once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = action_r;
  assign out_health         = health_r;
  assign out_ms_since_frame = since_r;

endmodule

`default_nettype wire
